/* hdl/path_normalizer_assert.svh */
// Assertion macros shared by the path normalizer checker.
`ifndef PATH_NORMALIZER_ASSERT_SVH
`define PATH_NORMALIZER_ASSERT_SVH

// Clocked assertion with reset disable, using clk and arst_n from the enclosing scope.
`define PN_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// A stalled output word keeps the given signal unchanged in the next cycle.
`define PN_ASSERT_HOLD(lbl, sig) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) \
		(out_valid && !out_ready) |=> $stable(sig)) else $error("Output word changed while stalled.");

`endif

/* hdl/pn_pkg.sv */
// Package with types and constants of the path normalizer.
package pn_pkg;
	localparam int PN_PATH_LIMIT = 256;
	localparam int STORE_DEPTH = 256;
	localparam int STACK_DEPTH = 128;
	localparam int QUEUE_DEPTH = 4;
	localparam logic [8:0] CAP_RESET = 9'd256;
	localparam logic [8:0] CAP_MAX = 9'd256;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	typedef enum logic [1:0] {
		OP_DIR = 2'd0,
		OP_ARG = 2'd1,
		OP_FIN = 2'd2,
		OP_READ = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		PH_DIR = 2'd0,
		PH_REL = 2'd1,
		PH_ABS = 2'd2
	} phase_t;

	typedef struct packed {
		op_t op;
		logic [7:0] ch;
		logic [7:0] idx;
		logic slash;
		logic dot;
		logic bslash;
	} item_t;
endpackage

/* hdl/pn_front.sv */
// Front end: takes words, drops null DIR/ARG characters and classifies the rest.
module pn_front import pn_pkg::*; (
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] op,
	input  logic [7:0] char_in,
	input  logic [7:0] read_index,
	input  logic       q_full,
	output logic       q_push,
	output item_t      q_item
);
	logic drop;

	assign in_ready = !q_full;
	assign drop = (op == OP_DIR || op == OP_ARG) && char_in == 8'd0;
	assign q_push = in_valid && !q_full && !drop;

	always_comb begin
		q_item.op = op_t'(op);
		q_item.ch = char_in;
		q_item.idx = read_index;
		q_item.slash = char_in == CH_SLASH;
		q_item.dot = char_in == CH_DOT;
		q_item.bslash = char_in == CH_BSLASH;
	end
endmodule

/* hdl/pn_queue.sv */
// Small queue of classified words between the front and back ends.
module pn_queue import pn_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output logic  head_valid,
	output item_t head
);
	localparam int PW = $clog2(QUEUE_DEPTH);

	item_t mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0] count_q;

	assign full = count_q == (PW+1)'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

/* hdl/pn_back.sv */
// Back end: segment bookkeeping, path store, separator stack and result register.
module pn_back import pn_pkg::*; #(
	parameter int PATH_LIMIT = PN_PATH_LIMIT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [8:0] capacity,
	input  logic       head_valid,
	input  item_t      head,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       ok,
	output logic [7:0] path_length,
	output logic [7:0] char_out
);
	localparam int CW = $clog2(PATH_LIMIT + 1);

	logic [7:0] store_q [STORE_DEPTH];
	logic [7:0] stack_q [STACK_DEPTH];

	logic [8:0] out_len_q, out_len_n;
	logic [7:0] depth_q, depth_n;
	logic [8:0] seg_len_q, seg_len_n;
	logic not_dots_q, not_dots_n, bs_q, bs_n;
	logic [CW-1:0] dir_cnt_q, dir_cnt_n, arg_cnt_q, arg_cnt_n;
	phase_t phase_q, phase_n;
	logic dfs_q, dfs_n, failed_q, failed_n, pend_q, pend_n;
	logic [8:0] rep_len_q, rep_len_n;
	logic res_v_q, res_ok_q, res_rd_q, res_hit_q, res_root_q;
	logic [7:0] res_len_q;
	logic [7:0] st_rd_q, sk_rd_q;

	logic st_we, st_re, sk_we, sk_re;
	logic [7:0] st_wa, st_wd, sk_wd;
	logic [6:0] sk_wa, sk_ra;

	logic es_skip, es_pop, es_bsf, es_capf, es_push, es_fail, pop_read;
	logic [8:0] es_out, eff_cap;
	logic [10:0] cap_sum, pos;
	logic sep_one;
	logic needs_out, fire, split, item_es, arg_dir, do_dir, fin_ok;
	logic [CW+1:0] joined;

	assign sep_one = out_len_q > 9'd1;
	assign eff_cap = capacity > CAP_MAX ? CAP_MAX : capacity;
	assign cap_sum = 11'(out_len_q) + 11'(seg_len_q) + 11'd2;
	assign es_skip = seg_len_q == '0 || failed_q || (!not_dots_q && seg_len_q == 9'd1);
	assign es_pop = !es_skip && !not_dots_q && seg_len_q == 9'd2;
	assign es_bsf = !es_skip && !es_pop && bs_q;
	assign es_capf = !es_skip && !es_pop && !bs_q && cap_sum > 11'(eff_cap);
	assign es_push = !es_skip && !es_pop && !es_bsf && !es_capf;
	assign es_fail = failed_q || es_bsf || es_capf;
	assign pop_read = es_pop && depth_q != '0;
	assign es_out = es_push ? out_len_q + 9'(sep_one) + seg_len_q :
		(es_pop && depth_q == '0) ? 9'd1 : out_len_q;
	assign pos = 11'(out_len_q) + 11'(sep_one) + 11'(seg_len_q);

	assign do_dir = head.op == OP_DIR && phase_q == PH_DIR;
	assign arg_dir = head.op == OP_ARG && phase_q == PH_DIR;
	assign item_es = (do_dir && head.slash) || head.op == OP_FIN ||
		(head.op == OP_ARG && (arg_dir ? !head.slash : head.slash));
	assign split = item_es && (pop_read || (arg_dir && !head.slash && seg_len_q != '0));
	assign needs_out = head.op == OP_FIN || head.op == OP_READ;
	assign fire = head_valid && !pend_q && (!needs_out || !res_v_q || out_ready);
	assign pop = fire && !split;

	always_comb begin
		unique case (phase_q)
			PH_DIR: joined = (CW+2)'(dir_cnt_q);
			PH_ABS: joined = (CW+2)'(arg_cnt_q);
			default: joined = (CW+2)'(dir_cnt_q) + (CW+2)'(arg_cnt_q) +
				(CW+2)'(!(dir_cnt_q == CW'(1) && dfs_q));
		endcase
	end
	assign fin_ok = !es_fail && capacity >= 9'd2 && joined < (CW+2)'(PATH_LIMIT);

	always_comb begin
		out_len_n = out_len_q;
		depth_n = depth_q;
		seg_len_n = seg_len_q;
		not_dots_n = not_dots_q;
		bs_n = bs_q;
		dir_cnt_n = dir_cnt_q;
		arg_cnt_n = arg_cnt_q;
		phase_n = phase_q;
		dfs_n = dfs_q;
		failed_n = failed_q;
		pend_n = 1'b0;
		rep_len_n = rep_len_q;
		st_we = 1'b0;
		st_wa = out_len_q[7:0];
		st_wd = CH_SLASH;
		st_re = 1'b0;
		sk_we = 1'b0;
		sk_wa = depth_q[6:0];
		sk_wd = out_len_q[7:0];
		sk_re = 1'b0;
		sk_ra = 7'(depth_q - 8'd1);
		if (pend_q) begin
			out_len_n = {1'b0, sk_rd_q};
		end else if (fire) begin
			if (item_es) begin
				seg_len_n = '0;
				not_dots_n = 1'b0;
				bs_n = 1'b0;
				out_len_n = es_out;
				failed_n = es_fail;
				st_we = es_push && sep_one;
				sk_we = es_push && !depth_q[7];
				if (es_push && !depth_q[7]) begin
					depth_n = depth_q + 8'd1;
				end
				if (pop_read) begin
					depth_n = depth_q - 8'd1;
					sk_re = 1'b1;
					pend_n = 1'b1;
				end
			end
			if (!split) begin
				unique case (head.op)
					OP_DIR: begin
						if (do_dir) begin
							if (dir_cnt_q == '0) begin
								dfs_n = head.slash;
							end
							if (dir_cnt_q < CW'(PATH_LIMIT)) begin
								dir_cnt_n = dir_cnt_q + 1'b1;
							end
						end
					end
					OP_ARG: begin
						if (arg_cnt_q < CW'(PATH_LIMIT)) begin
							arg_cnt_n = arg_cnt_q + 1'b1;
						end
						if (arg_dir && head.slash) begin
							out_len_n = 9'd1;
							depth_n = '0;
							seg_len_n = '0;
							not_dots_n = 1'b0;
							bs_n = 1'b0;
							failed_n = 1'b0;
							phase_n = PH_ABS;
						end else if (arg_dir) begin
							phase_n = PH_REL;
						end
					end
					OP_FIN: begin
						rep_len_n = fin_ok ? es_out : 9'd0;
						out_len_n = 9'd1;
						depth_n = '0;
						seg_len_n = '0;
						not_dots_n = 1'b0;
						bs_n = 1'b0;
						dir_cnt_n = '0;
						arg_cnt_n = '0;
						phase_n = PH_DIR;
						dfs_n = 1'b0;
						failed_n = 1'b0;
					end
					OP_READ: begin
						st_re = 1'b1;
					end
					default: begin
					end
				endcase
				if ((do_dir || head.op == OP_ARG) && !head.slash) begin
					st_we = pos < 11'(STORE_DEPTH);
					st_wa = pos[7:0];
					st_wd = head.ch;
					if (!head.dot) begin
						not_dots_n = 1'b1;
					end
					if (head.bslash) begin
						bs_n = 1'b1;
					end
					if (seg_len_q != 9'h1FF) begin
						seg_len_n = seg_len_q + 9'd1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st_we) begin
			store_q[st_wa] <= st_wd;
		end
		if (st_re) begin
			st_rd_q <= store_q[head.idx];
		end
		if (sk_we) begin
			stack_q[sk_wa] <= sk_wd;
		end
		if (sk_re) begin
			sk_rd_q <= stack_q[sk_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (pop && needs_out) begin
			res_rd_q <= head.op == OP_READ;
			res_ok_q <= head.op == OP_FIN && fin_ok;
			res_len_q <= (head.op == OP_FIN && fin_ok) ? es_out[7:0] : 8'd0;
			res_hit_q <= 9'(head.idx) < rep_len_q;
			res_root_q <= head.idx == 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_len_q <= 9'd1;
			depth_q <= '0;
			seg_len_q <= '0;
			not_dots_q <= 1'b0;
			bs_q <= 1'b0;
			dir_cnt_q <= '0;
			arg_cnt_q <= '0;
			phase_q <= PH_DIR;
			dfs_q <= 1'b0;
			failed_q <= 1'b0;
			pend_q <= 1'b0;
			rep_len_q <= '0;
			res_v_q <= 1'b0;
		end else begin
			out_len_q <= out_len_n;
			depth_q <= depth_n;
			seg_len_q <= seg_len_n;
			not_dots_q <= not_dots_n;
			bs_q <= bs_n;
			dir_cnt_q <= dir_cnt_n;
			arg_cnt_q <= arg_cnt_n;
			phase_q <= phase_n;
			dfs_q <= dfs_n;
			failed_q <= failed_n;
			pend_q <= pend_n;
			rep_len_q <= rep_len_n;
			if (pop && needs_out) begin
				res_v_q <= 1'b1;
			end else if (out_ready) begin
				res_v_q <= 1'b0;
			end
		end
	end

	assign out_valid = res_v_q;
	assign ok = res_ok_q;
	assign path_length = res_len_q;
	assign char_out = (res_rd_q && res_hit_q) ? (res_root_q ? CH_SLASH : st_rd_q) : 8'd0;
endmodule

/* hdl/path_normalizer.sv */
// Top level of the path normalizer: capacity register, front end, queue and back end.
// Flow: a finish or read word passes the queue and then the result register; a ".."
// segment that pops a kept segment holds the queue while the separator stack is read,
// and a relative argument byte that closes an open directory segment is taken again.
// Throughput: one word per cycle unless the output stalls or the queue is held as above.
// Reset: asynchronous, active low; clears all control state and sets capacity to 256.
module path_normalizer import pn_pkg::*; #(
	parameter int PATH_LIMIT = PN_PATH_LIMIT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] op,
	input  logic [7:0] char_in,
	input  logic [7:0] read_index,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       ok,
	output logic [7:0] path_length,
	output logic [7:0] char_out,
	input  logic       cfg_we,
	input  logic [8:0] cfg_data
);
	logic [8:0] cap_q;
	logic q_full, q_push, q_pop, head_valid;
	item_t q_item, head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_data;
		end
	end

	pn_front u_front (
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.char_in   (char_in),
		.read_index(read_index),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_item    (q_item)
	);

	pn_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_item),
		.full      (q_full),
		.pop       (q_pop),
		.head_valid(head_valid),
		.head      (head)
	);

	pn_back #(.PATH_LIMIT(PATH_LIMIT)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.capacity   (cap_q),
		.head_valid (head_valid),
		.head       (head),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.ok         (ok),
		.path_length(path_length),
		.char_out   (char_out)
	);
endmodule

/* hdl/pn_checker.sv */
// Port checker for the path normalizer and its bind to the top level.
`include "path_normalizer_assert.svh"
module pn_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic       ok,
	input logic [7:0] path_length,
	input logic [7:0] char_out
);
	`PN_ASSERT(a_out_hold, (out_valid && !out_ready) |=> out_valid, "Output word dropped.")
	`PN_ASSERT_HOLD(a_len_hold, path_length)
	`PN_ASSERT(a_ok_len, (out_valid && ok) |-> path_length != 8'd0, "Success with zero length.")
	`PN_ASSERT(a_ok_char, (out_valid && ok) |-> char_out == 8'd0, "Finish word carries a byte.")
	`PN_ASSERT(a_fail_len, (out_valid && !ok) |-> path_length == 8'd0, "Failure reports a length.")
endmodule

bind path_normalizer pn_checker u_chk (.*);

/* bench/tb_path_normalizer.sv */
// Self-checking bench for path_normalizer: canonical path predictor, random traffic, stalls.
module tb_path_normalizer;
	import pn_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int HOLD_CYCLES = 300;

	typedef struct {
		bit ok;
		bit [7:0] len;
		bit [7:0] ch;
	} path_word_t;

	class canon_path_tracker;
		byte unsigned store[256];
		byte unsigned seps[128];
		int unsigned depth, olen, slen, sflags, dcount, acount, rep_len, cap;
		phase_t ph;
		bit dfirst, failed;
		path_word_t awaited_words[$];
		int mism, finishes, reads, good_paths;

		function new();
			foreach (store[i]) store[i] = 0;
			foreach (seps[i]) seps[i] = 0;
			cap = 256;
			rep_len = 0;
			mism = 0;
			finishes = 0;
			reads = 0;
			good_paths = 0;
			clear_work();
		endfunction

		function void clear_work();
			store[0] = CH_SLASH;
			olen = 1;
			depth = 0;
			slen = 0;
			sflags = 0;
			dcount = 0;
			acount = 0;
			ph = PH_DIR;
			dfirst = 0;
			failed = 0;
		endfunction

		function int unsigned eff_cap();
			return (cap > 256) ? 256 : cap;
		endfunction

		function void close_segment();
			int unsigned len, fl;
			len = slen;
			fl = sflags;
			slen = 0;
			sflags = 0;
			if (len == 0 || failed) return;
			if (!fl[0] && len == 1) return;
			if (!fl[0] && len == 2) begin
				if (depth > 0) begin
					depth--;
					olen = seps[depth & 127];
				end else begin
					olen = 1;
				end
				return;
			end
			if (fl[1] || olen + len + 2 > eff_cap()) begin
				failed = 1;
				return;
			end
			if (olen > 1) store[olen & 255] = CH_SLASH;
			if (depth < 128) begin
				seps[depth] = olen[7:0];
				depth++;
			end
			olen += ((olen > 1) ? 1 : 0) + len;
		endfunction

		function void add_char(bit [7:0] c);
			int unsigned pos;
			if (c == CH_SLASH) begin
				close_segment();
				return;
			end
			pos = olen + ((olen > 1) ? 1 : 0) + slen;
			if (pos < 256) store[pos] = c;
			if (c != CH_DOT) sflags |= 1;
			if (c == CH_BSLASH) sflags |= 2;
			slen++;
		endfunction

		function int unsigned sat_inc(int unsigned v);
			return (v < PN_PATH_LIMIT) ? v + 1 : v;
		endfunction

		function void note_input(op_t op, bit [7:0] c, bit [7:0] idx);
			path_word_t w;
			int unsigned joined;
			bit good;
			case (op)
				OP_DIR: begin
					if (c == 0 || ph != PH_DIR) return;
					if (dcount == 0) dfirst = (c == CH_SLASH);
					dcount = sat_inc(dcount);
					add_char(c);
				end
				OP_ARG: begin
					if (c == 0) return;
					if (ph == PH_DIR) begin
						if (c == CH_SLASH) begin
							olen = 1;
							depth = 0;
							slen = 0;
							sflags = 0;
							failed = 0;
							ph = PH_ABS;
						end else begin
							close_segment();
							ph = PH_REL;
						end
					end
					acount = sat_inc(acount);
					add_char(c);
				end
				OP_FIN: begin
					close_segment();
					if (ph == PH_DIR) joined = dcount;
					else if (ph == PH_ABS) joined = acount;
					else joined = dcount + ((dcount == 1 && dfirst) ? 0 : 1) + acount;
					good = !failed && cap >= 2 && joined < PN_PATH_LIMIT;
					rep_len = good ? olen : 0;
					w.ok = good;
					w.len = rep_len[7:0];
					w.ch = 0;
					awaited_words.push_back(w);
					finishes++;
					good_paths += good;
					clear_work();
				end
				default: begin
					w.ok = 0;
					w.len = 0;
					w.ch = (idx < rep_len) ? store[idx] : 8'd0;
					awaited_words.push_back(w);
					reads++;
				end
			endcase
		endfunction

		function void check_output(bit ok_a, bit [7:0] len_a, bit [7:0] ch_a);
			path_word_t w;
			if (awaited_words.size() == 0) begin
				mism++;
				if (mism <= 10)
					$display("Unexpected output word: ok=%0d len=%0d char=%0d", ok_a, len_a, ch_a);
				return;
			end
			w = awaited_words.pop_front();
			if (w.ok != ok_a || w.len != len_a || w.ch != ch_a) begin
				mism++;
				if (mism <= 10)
					$display("Mismatch: expected ok=%0d len=%0d char=%0d, got ok=%0d len=%0d char=%0d",
						w.ok, w.len, w.ch, ok_a, len_a, ch_a);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic [1:0] op = OP_DIR;
	logic [7:0] char_in = 0;
	logic [7:0] read_index = 0;
	logic out_valid;
	logic out_ready = 0;
	logic ok;
	logic [7:0] path_length;
	logic [7:0] char_out;
	logic cfg_we = 0;
	logic [8:0] cfg_data = 0;

	canon_path_tracker tracker = new();
	int sent = 0;
	int idle_cycles = 0;
	bit calm = 0;
	bit hold_req = 0;

	path_normalizer dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .char_in(char_in), .read_index(read_index),
		.out_valid(out_valid), .out_ready(out_ready),
		.ok(ok), .path_length(path_length), .char_out(char_out),
		.cfg_we(cfg_we), .cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) tracker.note_input(op_t'(op), char_in, read_index);
			if (out_valid && out_ready) tracker.check_output(ok, path_length, char_out);
			if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL path_normalizer");
				$finish;
			end
		end
	end

	function automatic int pick_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	initial begin
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready = 0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 0;
				out_ready = 1;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				out_ready = 0;
				repeat (pick_gap()) @(negedge clk);
				out_ready = 1;
			end else begin
				out_ready = 1;
			end
		end
	end

	task automatic send_word(op_t o, bit [7:0] c, bit [7:0] idx);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 0;
			repeat (gap) @(negedge clk);
		end
		op = o;
		char_in = c;
		read_index = idx;
		in_valid = 1;
		do @(posedge clk); while (!in_ready);
		sent++;
	endtask

	task automatic send_text(op_t o, string s);
		for (int i = 0; i < s.len(); i++) send_word(o, s[i], 8'($urandom));
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid = 0;
		while (tracker.awaited_words.size() != 0) @(posedge clk);
		repeat (12) @(negedge clk);
	endtask

	task automatic write_capacity(bit [8:0] v);
		drain();
		cfg_we = 1;
		cfg_data = v;
		@(negedge clk);
		cfg_we = 0;
		tracker.cap = v;
	endtask

	function automatic bit [7:0] pick_char();
		case ($urandom_range(0, 11))
			0, 1, 2: return CH_SLASH;
			3, 4: return CH_DOT;
			5: return ($urandom_range(0, 2) == 0) ? CH_BSLASH : 8'h61;
			6, 7, 8, 9: return 8'(8'h61 + $urandom_range(0, 25));
			10: return 8'($urandom_range(1, 255));
			default: return ($urandom_range(0, 9) == 0) ? 8'd0 : 8'h62;
		endcase
	endfunction

	task automatic random_request(int max_len);
		int n;
		n = $urandom_range(0, max_len);
		for (int i = 0; i < n; i++) begin
			if (i == 0 && $urandom_range(0, 1)) send_word(OP_DIR, CH_SLASH, 8'($urandom));
			else send_word(OP_DIR, pick_char(), 8'($urandom));
			if ($urandom_range(0, 60) == 0) send_word(OP_READ, 0, 8'($urandom));
		end
		n = $urandom_range(0, max_len);
		for (int i = 0; i < n; i++) begin
			send_word(OP_ARG, pick_char(), 8'($urandom));
			if ($urandom_range(0, 40) == 0) send_word(OP_DIR, pick_char(), 8'($urandom));
		end
		if ($urandom_range(0, 15) != 0) send_word(OP_FIN, 8'($urandom), 8'($urandom));
		n = $urandom_range(0, 4);
		for (int i = 0; i < n; i++)
			send_word(OP_READ, 8'($urandom),
				8'(($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 24)));
	endtask

	initial begin
		bit [8:0] caps[10];
		caps = '{9'd256, 9'd511, 9'd300, 9'd40, 9'd12, 9'd2, 9'd1, 9'd0, 9'd3, 9'd256};
		caps[8] = 9'($urandom_range(3, 255));
		repeat (8) @(negedge clk);
		arst_n = 1;

		send_word(OP_READ, 0, 0);
		send_text(OP_DIR, "/a/b");
		send_text(OP_ARG, "../c");
		send_word(OP_FIN, 0, 0);
		send_word(OP_READ, 0, 0);
		send_word(OP_READ, 0, 3);
		send_word(OP_READ, 0, 255);
		send_text(OP_ARG, "/x\\");
		send_word(OP_FIN, 0, 0);
		send_word(OP_DIR, 0, 0);
		send_text(OP_DIR, "/");
		send_text(OP_ARG, "...");
		send_word(OP_FIN, 8'hFF, 8'hFF);

		for (int p = 0; p < 10; p++) begin
			write_capacity(caps[p]);
			calm = (p % 3 == 2);
			if (p == 1) begin
				hold_req = 1;
				for (int i = 0; i < 40; i++) send_word(OP_READ, 0, 8'(i));
			end
			while (sent < 30 + (p + 1) * 190) begin
				if ($urandom_range(0, 40) == 0) random_request(300);
				else random_request(12);
			end
		end
		drain();
		$display("Sent %0d words: %0d finishes (%0d normalized), %0d reads, 10 capacity settings.",
			sent, tracker.finishes, tracker.good_paths, tracker.reads);
		if (tracker.mism == 0 && tracker.awaited_words.size() == 0) begin
			$display("PASS path_normalizer");
		end else begin
			$display("Mismatches: %0d", tracker.mism);
			$display("FAIL path_normalizer");
		end
		$finish;
	end
endmodule

/* sim.f */
+incdir+hdl
hdl/pn_pkg.sv
hdl/pn_front.sv
hdl/pn_queue.sv
hdl/pn_back.sv
hdl/path_normalizer.sv
hdl/pn_checker.sv
bench/tb_path_normalizer.sv
